>>> rtl/core/sbgr_pkg.sv
// ----------------------------------------------------------------------------
// sbgr_pkg
// Shared widths, register indexes and controller command type for the
// stereo balance gain ramp block.
// ----------------------------------------------------------------------------
package sbgr_pkg;

    // Channel count limit and derived position width
    localparam int MAX_CHANNELS = 32;
    localparam int POS_W        = $clog2(MAX_CHANNELS);
    localparam int TOTAL_W      = 6;

    // Field widths
    localparam int SAMPLE_W  = 24;
    localparam int GAIN_W    = 24;
    localparam int BAL_W     = 17;
    localparam int COEFF_W   = 25;
    localparam int CFG_W     = 25;
    localparam int CFG_IDX_W = 2;

    // Fixed-point constants
    localparam logic [GAIN_W-1:0]  UNITY_GAIN = 24'd8388608;
    localparam logic [COEFF_W-1:0] COEFF_ONE  = 25'd16777216;
    localparam logic signed [BAL_W-1:0] BAL_MAX = 17'sd32768;
    localparam logic signed [BAL_W-1:0] BAL_MIN = -17'sd32768;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BALANCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd2;

    // Configuration reset values
    localparam logic [COEFF_W-1:0] COEFF_RESET    = 25'd6989;
    localparam logic [TOTAL_W-1:0] CHANNELS_RESET = 6'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;   // take a sample beat, ramp gains at frame start
        logic snap;   // set gains to targets, restart frame
        logic emit;   // load the output register with the scaled sample
    } sbgr_cmd_t;

endpackage

>>> rtl/core/sbgr_ctrl.sv
// ----------------------------------------------------------------------------
// sbgr_ctrl
// Controller: takes input beats, sequences the multiply step and owns the
// output valid flag.
// ----------------------------------------------------------------------------
module sbgr_ctrl
    import sbgr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic       s_kind,
    output logic       m_tvalid,
    input  logic       m_tready,
    output sbgr_cmd_t  cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_MUL  = 1'b1;

    logic state_reg, state_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic in_beat;
    logic out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;

    // Decode commands and next state
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    if (s_kind) begin
                        cmd.snap = 1'b1;
                    end else begin
                        cmd.load   = 1'b1;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                if (out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result until the receiver takes it
    always_comb begin
        if (cmd.emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // A sample beat always leads to the multiply step
    a_sample_to_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_beat && !s_kind) |=> (state_reg == ST_MUL))
        else $error("sample beat did not start multiply step");

    // A snap beat produces no result
    a_snap_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_beat && s_kind) |=> (state_reg == ST_IDLE) && !$rose(m_tvalid_reg))
        else $error("snap beat produced a result");

    // A new result appears only after the multiply step
    a_result_from_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_MUL))
        else $error("result raised outside multiply step");

    // Never overwrite a result the receiver has not taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_tvalid_reg || m_tready))
        else $error("result overwritten while stalled");

endmodule

>>> rtl/core/sbgr_dp.sv
// ----------------------------------------------------------------------------
// sbgr_dp
// Datapath: configuration registers, gain ramp, channel position and the
// sample-by-gain product with its output register.
// ----------------------------------------------------------------------------
module sbgr_dp
    import sbgr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sbgr_cmd_t             cmd,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wr_data,
    input  logic [SAMPLE_W-1:0]   in_sample,
    output logic [SAMPLE_W-1:0]   out_sample,
    output logic [POS_W-1:0]      channel_index,
    output logic                  frame_end
);

    logic signed [BAL_W-1:0]  balance_reg;
    logic [COEFF_W-1:0]       coeff_reg;
    logic [TOTAL_W-1:0]       total_reg;
    logic [GAIN_W-1:0]        gain_l_reg, gain_l_next;
    logic [GAIN_W-1:0]        gain_r_reg, gain_r_next;
    logic [POS_W-1:0]         pos_reg, pos_next;

    logic [SAMPLE_W-1:0]      sample_reg;
    logic [POS_W-1:0]         cur_pos_reg;
    logic                     cur_last_reg;
    logic [SAMPLE_W-1:0]      out_sample_reg;
    logic [POS_W-1:0]         out_pos_reg;
    logic                     out_last_reg;

    logic signed [BAL_W-1:0]  bal_clamped;
    logic [GAIN_W-1:0]        left_target;
    logic [GAIN_W-1:0]        right_target;
    logic [COEFF_W-1:0]       coeff_eff;
    logic [TOTAL_W-1:0]       total_eff;
    logic [POS_W-1:0]         pos_eff;
    logic                     pos_last;
    logic [GAIN_W-1:0]        left_ramped;
    logic [GAIN_W-1:0]        right_ramped;
    logic [GAIN_W-1:0]        sel_gain;
    logic signed [48:0]       prod;
    logic signed [48:0]       prod_shift;

    // One step of the one-pole ramp, floored
    function automatic logic [GAIN_W-1:0] ramp_step(
        input logic [GAIN_W-1:0]  gain,
        input logic [GAIN_W-1:0]  target,
        input logic [COEFF_W-1:0] c
    );
        logic signed [GAIN_W:0] diff;
        logic signed [50:0]     p;
        logic signed [50:0]     sum;
        diff = $signed({1'b0, target}) - $signed({1'b0, gain});
        p    = 51'(diff) * 51'($signed({1'b0, c}));
        sum  = $signed({27'd0, gain}) + (p >>> 24);
        return sum[GAIN_W-1:0];
    endfunction

    // Clamp balance and derive the two targets
    always_comb begin
        if (balance_reg > BAL_MAX) begin
            bal_clamped = BAL_MAX;
        end else if (balance_reg < BAL_MIN) begin
            bal_clamped = BAL_MIN;
        end else begin
            bal_clamped = balance_reg;
        end
        if (bal_clamped[BAL_W-1]) begin
            left_target  = UNITY_GAIN;
            right_target = UNITY_GAIN - {bal_clamped[15:0] ^ 16'hFFFF, 8'd0} - 24'd256;
        end else begin
            left_target  = UNITY_GAIN - {bal_clamped[15:0], 8'd0}
                           - {bal_clamped[16], 23'd0};
            right_target = UNITY_GAIN;
        end
    end

    // Clamp coefficient and channel count
    assign coeff_eff = (coeff_reg > COEFF_ONE) ? COEFF_ONE : coeff_reg;
    always_comb begin
        if (total_reg < TOTAL_W'(2)) begin
            total_eff = TOTAL_W'(2);
        end else if (total_reg > TOTAL_W'(MAX_CHANNELS)) begin
            total_eff = TOTAL_W'(MAX_CHANNELS);
        end else begin
            total_eff = total_reg;
        end
    end

    // Restart the frame when the position ran past a lowered count
    assign pos_eff  = ({1'b0, pos_reg} >= total_eff) ? '0 : pos_reg;
    assign pos_last = ({1'b0, pos_eff} == (total_eff - TOTAL_W'(1)));

    assign left_ramped  = ramp_step(gain_l_reg, left_target, coeff_eff);
    assign right_ramped = ramp_step(gain_r_reg, right_target, coeff_eff);

    // Update gains and position
    always_comb begin
        gain_l_next = gain_l_reg;
        gain_r_next = gain_r_reg;
        pos_next    = pos_reg;
        if (cmd.snap) begin
            gain_l_next = left_target;
            gain_r_next = right_target;
            pos_next    = '0;
        end else if (cmd.load) begin
            if (pos_eff == '0) begin
                gain_l_next = left_ramped;
                gain_r_next = right_ramped;
            end
            pos_next = pos_last ? '0 : pos_eff + POS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            balance_reg <= '0;
            coeff_reg   <= COEFF_RESET;
            total_reg   <= CHANNELS_RESET;
            gain_l_reg  <= UNITY_GAIN;
            gain_r_reg  <= UNITY_GAIN;
            pos_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_BALANCE:  balance_reg <= $signed(cfg_wr_data[BAL_W-1:0]);
                    REG_COEFF:    coeff_reg   <= cfg_wr_data[COEFF_W-1:0];
                    REG_CHANNELS: total_reg   <= cfg_wr_data[TOTAL_W-1:0];
                    default: ;
                endcase
            end
            gain_l_reg <= gain_l_next;
            gain_r_reg <= gain_r_next;
            pos_reg    <= pos_next;
        end
    end

    // Capture the sample beat
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sample_reg   <= in_sample;
            cur_pos_reg  <= pos_eff;
            cur_last_reg <= pos_last;
        end
    end

    // Scale by the channel gain, floored
    assign sel_gain   = cur_pos_reg[0] ? gain_r_reg : gain_l_reg;
    assign prod       = 49'($signed(sample_reg)) * 49'($signed({1'b0, sel_gain}));
    assign prod_shift = prod >>> 23;

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_sample_reg <= prod_shift[SAMPLE_W-1:0];
            out_pos_reg    <= cur_pos_reg;
            out_last_reg   <= cur_last_reg;
        end
    end

    assign out_sample    = out_sample_reg;
    assign channel_index = out_pos_reg;
    assign frame_end     = out_last_reg;

endmodule

>>> rtl/core/stereo_balance_gain_ramp.sv
// ----------------------------------------------------------------------------
// stereo_balance_gain_ramp
// Stereo balance with one-pole smoothed left and right gains.
//
// Input beats carry one interleaved Q1.23 sample in s_tdata; s_tuser set
// marks a snap beat, which sets both gains to their balance targets,
// restarts the frame at channel 0 and produces no output beat.
// Each sample beat produces one output beat: the sample scaled by the left
// gain (even channels) or right gain (odd channels), with its channel
// position in m_tuser and m_tlast on the last channel of a frame. The gains
// ramp one step toward their targets at the first channel of every frame.
// A sample beat is captured, and the gains ramped, in the idle state; the
// multiply state then loads the scaled sample into the output register
// and raises m_tvalid. One input beat is in work at a time. When the
// receiver stalls, the result stays in the output register and the
// multiply step waits, so input stalls one beat later.
// Reset clears the gains to unity, the frame position to 0 and the
// configuration registers to their defaults. Write configuration only while
// the block is idle.
// ----------------------------------------------------------------------------
module stereo_balance_gain_ramp
    import sbgr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wr_data,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,    // [23:0] in_sample
    input  logic                  s_tuser,    // [0] kind
    // Output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,    // [23:0] out_sample
    output logic [POS_W-1:0]      m_tuser,    // [4:0] channel_index
    output logic                  m_tlast     // frame_end
);

    sbgr_cmd_t cmd;

    sbgr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_kind   (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    sbgr_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data),
        .in_sample     (s_tdata),
        .out_sample    (m_tdata),
        .channel_index (m_tuser),
        .frame_end     (m_tlast)
    );

endmodule
